// ===== hdl/fsbc_pkg.sv =====
`timescale 1ns / 1ps

package fsbc_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int COORD_W        = 32;
    localparam int NORM_W         = 18;
    localparam int FRAC_W         = 16;
    localparam int PROD_W         = COORD_W + NORM_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int THR_W          = COORD_W + 2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2
    } op_t;

    typedef struct packed {
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic signed [COORD_W-1:0] offset;
    } plane_t;

    typedef struct packed {
        logic                      is_box;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] extra;
    } query_t;

    // clamp a Q16.16 component into the Q2.16 normal range
    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] hi;
        logic signed [COORD_W-1:0] lo;
        hi = COORD_W'((1 << (NORM_W - 1)) - 1);
        lo = -COORD_W'(1 << (NORM_W - 1));
        if (v > hi)
        begin
            return hi[NORM_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[NORM_W-1:0];
        end
        return v[NORM_W-1:0];
    endfunction

endpackage

// ===== hdl/fsbc_ifs.sv =====
`timescale 1ns / 1ps

interface fsbc_query_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [2:0]        plane_index;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_a_z;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic signed [31:0] point_b_z;
    logic signed [31:0] extra_value;

    modport source (
        output valid, operation, plane_index, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z, extra_value,
        input  ready
    );
    modport sink (
        input  valid, operation, plane_index, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z, extra_value,
        output ready
    );
endinterface

interface fsbc_result_if;
    logic valid;
    logic ready;
    logic visible;
    logic is_test;

    modport source (
        output valid, visible, is_test,
        input  ready
    );
    modport sink (
        input  valid, visible, is_test,
        output ready
    );
endinterface

// ===== hdl/fsbc_plane_store.sv =====
`timescale 1ns / 1ps

module fsbc_plane_store #(
    parameter int NUM_PLANES = fsbc_pkg::NUM_PLANES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [2:0]                          wr_index,
    input  logic signed [fsbc_pkg::COORD_W-1:0] wr_nx,
    input  logic signed [fsbc_pkg::COORD_W-1:0] wr_ny,
    input  logic signed [fsbc_pkg::COORD_W-1:0] wr_nz,
    input  logic signed [fsbc_pkg::COORD_W-1:0] wr_offset,
    output fsbc_pkg::plane_t                    planes [NUM_PLANES]
);
    import fsbc_pkg::*;

    plane_t wr_plane;

    always_comb
    begin
        wr_plane.nx     = sat_norm(wr_nx);
        wr_plane.ny     = sat_norm(wr_ny);
        wr_plane.nz     = sat_norm(wr_nz);
        wr_plane.offset = wr_offset;
    end

    // an index beyond the plane count matches no slot and is dropped
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        plane_t plane_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg <= '0;
            end
            else if (wr_en && (32'(wr_index) == p))
            begin
                plane_reg <= wr_plane;
            end
        end

        assign planes[p] = plane_reg;
    end

endmodule

// ===== hdl/fsbc_plane_lane.sv =====
`timescale 1ns / 1ps

module fsbc_plane_lane (
    input  logic             clk,
    input  logic             adv,
    input  fsbc_pkg::query_t query,
    input  fsbc_pkg::plane_t plane,
    output logic             reject
);
    import fsbc_pkg::*;

    // stage 2: products and threshold
    logic signed [PROD_W-1:0] pa_x_reg, pa_y_reg, pa_z_reg;
    logic signed [PROD_W-1:0] pb_x_reg, pb_y_reg, pb_z_reg;
    logic                     box2_reg;
    logic signed [THR_W-1:0]  thr2_reg;
    logic signed [THR_W-1:0]  thr2_next;
    logic signed [THR_W-1:0]  d_ext;
    logic signed [THR_W-1:0]  r_ext;

    // stage 3: per-axis terms
    logic signed [PROD_W-1:0] t_x_reg, t_y_reg, t_z_reg;
    logic signed [THR_W-1:0]  thr3_reg;

    // stage 4: plane sum
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [THR_W-1:0]  thr4_reg;

    // stage 5: compare
    logic                     reject_reg;

    always_comb
    begin
        d_ext = THR_W'(plane.offset);
        r_ext = THR_W'(query.extra);
        // sphere: sum < -(r + d) scaled; box: sum < -d scaled
        if (query.is_box)
        begin
            thr2_next = -d_ext;
        end
        else
        begin
            thr2_next = -(d_ext + r_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_x_reg <= PROD_W'(query.ax) * PROD_W'(plane.nx);
            pa_y_reg <= PROD_W'(query.ay) * PROD_W'(plane.ny);
            pa_z_reg <= PROD_W'(query.az) * PROD_W'(plane.nz);
            pb_x_reg <= PROD_W'(query.bx) * PROD_W'(plane.nx);
            pb_y_reg <= PROD_W'(query.by) * PROD_W'(plane.ny);
            pb_z_reg <= PROD_W'(query.bz) * PROD_W'(plane.nz);
            box2_reg <= query.is_box;
            thr2_reg <= thr2_next;

            t_x_reg  <= (box2_reg && (pb_x_reg > pa_x_reg)) ? pb_x_reg : pa_x_reg;
            t_y_reg  <= (box2_reg && (pb_y_reg > pa_y_reg)) ? pb_y_reg : pa_y_reg;
            t_z_reg  <= (box2_reg && (pb_z_reg > pa_z_reg)) ? pb_z_reg : pa_z_reg;
            thr3_reg <= thr2_reg;

            sum_reg  <= SUM_W'(t_x_reg) + SUM_W'(t_y_reg) + SUM_W'(t_z_reg);
            thr4_reg <= thr3_reg;

            reject_reg <= sum_reg < (SUM_W'(thr4_reg) <<< FRAC_W);
        end
    end

    assign reject = reject_reg;

endmodule

// ===== hdl/frustum_sphere_box_cull.sv =====
`timescale 1ns / 1ps
// A taken query beat passes the query register, the lane stages and the output register.
// Throughput: one query per cycle; a single enable moves every stage, held while the
// output register is full and not taken.
// Each plane has its own lane of six 32x18 multipliers, summed and compared over three stages.
// Reset (rst_n, asynchronous): pipeline empties and all planes clear to zero.
module frustum_sphere_box_cull #(
    parameter int NUM_PLANES = fsbc_pkg::NUM_PLANES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fsbc_query_if.sink    query,
    fsbc_result_if.source result
);
    import fsbc_pkg::*;

    localparam int DEPTH = 5;

    logic             adv;
    logic             accept;
    logic             load_en;
    op_t              op;
    query_t           q_next;
    query_t           s1_reg;
    plane_t           planes [NUM_PLANES];
    logic [NUM_PLANES-1:0] reject;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] test_reg;
    logic             out_valid_reg;
    logic             visible_reg;
    logic             is_test_reg;
    logic             is_test_next;

    assign adv         = !out_valid_reg || result.ready;
    assign query.ready = adv;
    assign accept      = query.valid && adv;
    assign op          = op_t'(query.operation);

    always_comb
    begin
        load_en      = 1'b0;
        is_test_next = 1'b0;
        case (op)
            OP_LOAD:   load_en      = accept;
            OP_SPHERE: is_test_next = 1'b1;
            OP_BOX:    is_test_next = 1'b1;
            default:   is_test_next = 1'b0;
        endcase
        q_next.is_box = (op == OP_BOX);
        q_next.ax     = query.point_a_x;
        q_next.ay     = query.point_a_y;
        q_next.az     = query.point_a_z;
        q_next.bx     = query.point_b_x;
        q_next.by     = query.point_b_y;
        q_next.bz     = query.point_b_z;
        q_next.extra  = query.extra_value;
    end

    fsbc_plane_store #(
        .NUM_PLANES (NUM_PLANES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (load_en),
        .wr_index  (query.plane_index),
        .wr_nx     (query.point_a_x),
        .wr_ny     (query.point_a_y),
        .wr_nz     (query.point_a_z),
        .wr_offset (query.extra_value),
        .planes    (planes)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= q_next;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_lane
        fsbc_plane_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .query  (s1_reg),
            .plane  (planes[p]),
            .reject (reject[p])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            test_reg      <= '0;
            out_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
            is_test_reg   <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], accept};
            test_reg      <= {test_reg[DEPTH-2:0], is_test_next};
            out_valid_reg <= vld_reg[DEPTH-1];
            is_test_reg   <= test_reg[DEPTH-1];
            // loads and the unused code answer not visible
            visible_reg   <= test_reg[DEPTH-1] && !(|reject);
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.visible = visible_reg;
    assign result.is_test = is_test_reg;

endmodule
